[rtl/dpk_pkg.sv]
// ----------------------------------------------------------------------------
// dpk_pkg
// Shared constants, types and helpers for the DTMF peak key / passcode block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpk_pkg;

    // Spectrum and code geometry
    localparam int unsigned TRANSFORM_LENGTH = 1024;
    localparam int unsigned CODE_LENGTH      = 4;
    localparam int unsigned SAMPLE_RATE_HZ   = 20000;
    localparam int unsigned HALF_WINDOW_HZ   = 10;

    // Field widths
    localparam int unsigned BIN_W      = 9;
    localparam int unsigned MAG_W      = 23;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned ENTERED_W  = 3;
    localparam int unsigned VERDICT_W  = 2;
    localparam int unsigned PASS_W     = 16;
    localparam int unsigned CFG_DATA_W = 23;
    localparam int unsigned NUM_TONES  = 4;
    localparam int unsigned TONE_IDX_W = 2;

    // Key counter and entry slot widths follow from the code length
    localparam int unsigned CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int unsigned PASS_DIGITS = PASS_W / CODE_W;

    // Reset values of the configuration registers
    localparam logic [MAG_W-1:0]  THRESHOLD_RESET = MAG_W'(20000);
    localparam logic [PASS_W-1:0] PASSCODE_RESET  = PASS_W'(390);

    // Key count as reported on the output when the entry is complete
    localparam logic [ENTERED_W-1:0] ENTERED_FULL = ENTERED_W'(CODE_LENGTH);

    // DTMF tone frequencies in Hz
    localparam int unsigned ROW_TONE [NUM_TONES] = '{697, 770, 852, 941};
    localparam int unsigned COL_TONE [NUM_TONES] = '{1209, 1336, 1477, 1633};

    // Bin windows: (f-10)*N < bin*20000 < (f+10)*N, solved for bin at elaboration
    localparam int unsigned ROW_BIN_LO [NUM_TONES] = '{
        (ROW_TONE[0] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (ROW_TONE[1] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (ROW_TONE[2] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (ROW_TONE[3] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1
    };
    localparam int unsigned ROW_BIN_HI [NUM_TONES] = '{
        ((ROW_TONE[0] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((ROW_TONE[1] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((ROW_TONE[2] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((ROW_TONE[3] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ
    };
    localparam int unsigned COL_BIN_LO [NUM_TONES] = '{
        (COL_TONE[0] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (COL_TONE[1] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (COL_TONE[2] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1,
        (COL_TONE[3] - HALF_WINDOW_HZ) * TRANSFORM_LENGTH / SAMPLE_RATE_HZ + 1
    };
    localparam int unsigned COL_BIN_HI [NUM_TONES] = '{
        ((COL_TONE[0] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((COL_TONE[1] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((COL_TONE[2] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ,
        ((COL_TONE[3] + HALF_WINDOW_HZ) * TRANSFORM_LENGTH - 1) / SAMPLE_RATE_HZ
    };

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAG_THRESHOLD = 1'b0,
        CFG_PASSCODE_KEYS = 1'b1
    } t_cfg_reg;

    // Passcode verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_INCOMPLETE = 2'd0,
        VERDICT_CORRECT    = 2'd1,
        VERDICT_INCORRECT  = 2'd2
    } t_verdict;

    // Tone window hits for one bin
    typedef struct packed {
        logic                  row_hit;
        logic [TONE_IDX_W-1:0] row_idx;
        logic                  col_hit;
        logic [TONE_IDX_W-1:0] col_idx;
    } t_tone_hit;

    // Key decision handed from peak tracking to the entry check
    typedef struct packed {
        logic              fire;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } t_key_event;

    // Expected key at slot t; digits past the register read as zero
    function automatic logic [CODE_W-1:0] pass_digit(
        input logic [PASS_W-1:0] pass,
        input int unsigned       t
    );
        logic [CODE_W-1:0] digit;
        digit = '0;
        if (t < PASS_DIGITS) begin
            digit = pass[CODE_W*t +: CODE_W];
        end
        return digit;
    endfunction

endpackage

`default_nettype wire

[rtl/dpk_tone_match.sv]
// ----------------------------------------------------------------------------
// dpk_tone_match
// Maps a spectrum bin number onto the row and column DTMF tone windows.
// ----------------------------------------------------------------------------
`default_nettype none

module dpk_tone_match (
    input  wire logic [dpk_pkg::BIN_W-1:0] i_bin,
    output dpk_pkg::t_tone_hit             o_hit
);

    logic [31:0] w_bin_ext;

    assign w_bin_ext = 32'(i_bin);

    // Check each tone window; windows are disjoint, so at most one hits per group
    always_comb begin
        o_hit = '0;
        for (int t = 0; t < dpk_pkg::NUM_TONES; t++) begin
            if (w_bin_ext >= dpk_pkg::ROW_BIN_LO[t] && w_bin_ext <= dpk_pkg::ROW_BIN_HI[t]) begin
                o_hit.row_hit = 1'b1;
                o_hit.row_idx = dpk_pkg::TONE_IDX_W'(t);
            end
            if (w_bin_ext >= dpk_pkg::COL_BIN_LO[t] && w_bin_ext <= dpk_pkg::COL_BIN_HI[t]) begin
                o_hit.col_hit = 1'b1;
                o_hit.col_idx = dpk_pkg::TONE_IDX_W'(t);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dpk_peak_track.sv]
// ----------------------------------------------------------------------------
// dpk_peak_track
// Running row and column peaks over one capture, and the key decision at its
// last bin.
// ----------------------------------------------------------------------------
`default_nettype none

module dpk_peak_track (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [dpk_pkg::MAG_W-1:0]     i_mag,
    input  wire logic                          i_last,
    input  wire dpk_pkg::t_tone_hit            i_hit,
    input  wire logic [dpk_pkg::MAG_W-1:0]     i_threshold,
    output dpk_pkg::t_key_event                o_evt
);

    logic [dpk_pkg::MAG_W-1:0]      r_row_peak, n_row_peak;
    logic [dpk_pkg::MAG_W-1:0]      r_col_peak, n_col_peak;
    logic [dpk_pkg::TONE_IDX_W-1:0] r_row_idx, n_row_idx;
    logic [dpk_pkg::TONE_IDX_W-1:0] r_col_idx, n_col_idx;
    logic                           r_row_found, n_row_found;
    logic                           r_col_found, n_col_found;
    logic                           w_key_ok;

    // Take a bin as new peak only when strictly greater
    always_comb begin
        n_row_peak  = r_row_peak;
        n_row_idx   = r_row_idx;
        n_row_found = r_row_found;
        n_col_peak  = r_col_peak;
        n_col_idx   = r_col_idx;
        n_col_found = r_col_found;
        if (i_hit.row_hit && i_mag > r_row_peak) begin
            n_row_peak  = i_mag;
            n_row_idx   = i_hit.row_idx;
            n_row_found = 1'b1;
        end
        if (i_hit.col_hit && i_mag > r_col_peak) begin
            n_col_peak  = i_mag;
            n_col_idx   = i_hit.col_idx;
            n_col_found = 1'b1;
        end
    end

    // Decide the key from the peaks including this bin
    assign w_key_ok = n_row_found && n_col_found &&
                      (n_row_peak > i_threshold) && (n_col_peak > i_threshold);

    assign o_evt.fire      = i_step && i_last;
    assign o_evt.key_valid = w_key_ok;
    assign o_evt.key_code  = w_key_ok ? {n_row_idx, n_col_idx} : '0;

    // Advance peaks per bin, drop them after the last bin of a capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_peak  <= '0;
            r_col_peak  <= '0;
            r_row_idx   <= '0;
            r_col_idx   <= '0;
            r_row_found <= 1'b0;
            r_col_found <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_row_peak  <= '0;
                r_col_peak  <= '0;
                r_row_idx   <= '0;
                r_col_idx   <= '0;
                r_row_found <= 1'b0;
                r_col_found <= 1'b0;
            end else begin
                r_row_peak  <= n_row_peak;
                r_col_peak  <= n_col_peak;
                r_row_idx   <= n_row_idx;
                r_col_idx   <= n_col_idx;
                r_row_found <= n_row_found;
                r_col_found <= n_col_found;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dpk_entry_check.sv]
// ----------------------------------------------------------------------------
// dpk_entry_check
// Collects accepted keys into the entry, compares a full entry against the
// passcode and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpk_entry_check (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire dpk_pkg::t_key_event                i_evt,
    input  wire logic [dpk_pkg::PASS_W-1:0]         i_passcode,
    input  wire logic                               i_out_ready,
    output logic                                    o_valid,
    output logic                                    o_key_valid,
    output logic [dpk_pkg::CODE_W-1:0]              o_key_code,
    output logic [dpk_pkg::ENTERED_W-1:0]           o_keys_entered,
    output dpk_pkg::t_verdict                       o_verdict
);

    logic [dpk_pkg::CODE_W-1:0]    r_keys [dpk_pkg::CODE_LENGTH];
    logic [dpk_pkg::CODE_W-1:0]    n_keys [dpk_pkg::CODE_LENGTH];
    logic [dpk_pkg::CNT_W-1:0]     r_count, n_count;
    logic [dpk_pkg::CNT_W-1:0]     w_count_after;
    logic [dpk_pkg::IDX_W-1:0]     w_slot;
    logic [31:0]                   w_count_ext;
    logic                          w_full;
    logic                          w_match;
    dpk_pkg::t_verdict             w_verdict;

    logic                          r_o_valid;
    logic                          r_o_key_valid;
    logic [dpk_pkg::CODE_W-1:0]    r_o_code;
    logic [dpk_pkg::ENTERED_W-1:0] r_o_entered;
    dpk_pkg::t_verdict             r_o_verdict;

    assign w_slot = r_count[dpk_pkg::IDX_W-1:0];

    // Entry as it stands with this capture's key placed
    always_comb begin
        for (int t = 0; t < dpk_pkg::CODE_LENGTH; t++) begin
            n_keys[t] = r_keys[t];
            if (i_evt.key_valid && w_slot == dpk_pkg::IDX_W'(t)) begin
                n_keys[t] = i_evt.key_code;
            end
        end
    end

    // Count keys and compare a full entry digit by digit
    always_comb begin
        w_count_after = i_evt.key_valid ? r_count + 1'b1 : r_count;
        w_full        = (w_count_after == dpk_pkg::CNT_W'(dpk_pkg::CODE_LENGTH));
        w_match       = 1'b1;
        for (int t = 0; t < dpk_pkg::CODE_LENGTH; t++) begin
            if (n_keys[t] != dpk_pkg::pass_digit(i_passcode, t)) begin
                w_match = 1'b0;
            end
        end
        if (!w_full) begin
            w_verdict = dpk_pkg::VERDICT_INCOMPLETE;
        end else if (w_match) begin
            w_verdict = dpk_pkg::VERDICT_CORRECT;
        end else begin
            w_verdict = dpk_pkg::VERDICT_INCORRECT;
        end
        n_count     = w_full ? '0 : w_count_after;
        w_count_ext = 32'(w_count_after);
    end

    // Write the accepted key into its slot; the store needs no reset
    always_ff @(posedge i_clk) begin
        if (i_evt.fire && i_evt.key_valid) begin
            r_keys[w_slot] <= i_evt.key_code;
        end
    end

    // Advance the key count at most once per capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_evt.fire) begin
            r_count <= n_count;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_evt.fire) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.fire) begin
            r_o_key_valid <= i_evt.key_valid;
            r_o_code      <= i_evt.key_code;
            r_o_entered   <= w_count_ext[dpk_pkg::ENTERED_W-1:0];
            r_o_verdict   <= w_verdict;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_key_valid    = r_o_key_valid;
    assign o_key_code     = r_o_code;
    assign o_keys_entered = r_o_entered;
    assign o_verdict      = r_o_verdict;

`ifndef SYNTHESIS
    a_count_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < dpk_pkg::CNT_W'(dpk_pkg::CODE_LENGTH))
        else $error("key count reached full length without clearing");

    a_verdict_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_verdict != dpk_pkg::VERDICT_INCOMPLETE
            |-> r_o_entered == dpk_pkg::ENTERED_FULL)
        else $error("verdict given on an incomplete entry");

    a_rejected_key_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_key_valid
            |-> r_o_code == '0 && r_o_verdict == dpk_pkg::VERDICT_INCOMPLETE)
        else $error("rejected key carries a code or verdict");

    a_count_holds_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.fire && !i_evt.key_valid |=> $stable(r_count))
        else $error("key count moved on a rejected capture");
`endif

endmodule

`default_nettype wire

[rtl/dtmf_peak_key_passcode.sv]
// ----------------------------------------------------------------------------
// dtmf_peak_key_passcode
// DTMF key detection from spectrum bins with a four-key passcode check.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one spectrum bin per request: bin number and
//   magnitude in tdata, tlast on the final bin of a capture. Bins are taken
//   at one per cycle unless a final bin waits; the input register feeds the
//   peak logic directly. Only a request with tlast set produces a result on
//   m_axis: it passes the input register, then the result register, where
//   m_axis_tvalid rises. Sustained throughput is one bin per cycle while no
//   final bin waits, set by the single compare-and-update pass on the peak
//   registers.
//   When the receiver stalls, non-final bins keep flowing; a final bin waits
//   in the input register until the result register is free, and
//   s_axis_tready stays low while it waits.
//   Configuration writes on i_cfg_* take effect at the clock edge; write them
//   only while no capture is in flight.
//   Reset (synchronous, active low) empties both registers, clears the peaks
//   and the key count, and loads threshold 20000 and passcode keys 390.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_peak_key_passcode (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [0:0]                          i_cfg_index,
    input  wire logic [dpk_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // bin stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // bin_index[8:0], magnitude[31:9]
    input  wire logic [31:0]                         s_axis_tdata,  // bin_index, magnitude
    input  wire logic                                s_axis_tlast,  // last_bin
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // key_code[3:0], keys_entered[6:4], verdict[8:7], zeros[15:9]
    output logic [15:0]                              m_axis_tdata,  // key_code, entered, verdict
    output logic [0:0]                               m_axis_tuser   // key_valid
);

    logic                            r_in_valid;
    logic [dpk_pkg::BIN_W-1:0]       r_in_bin;
    logic [dpk_pkg::MAG_W-1:0]       r_in_mag;
    logic                            r_in_last;
    logic [dpk_pkg::MAG_W-1:0]       r_threshold;
    logic [dpk_pkg::PASS_W-1:0]      r_passcode;

    logic                            w_s_accept;
    logic                            w_step;
    logic                            w_out_free;
    logic                            w_out_valid;
    logic                            w_key_valid;
    logic [dpk_pkg::CODE_W-1:0]      w_key_code;
    logic [dpk_pkg::ENTERED_W-1:0]   w_entered;
    dpk_pkg::t_verdict               w_verdict;
    dpk_pkg::t_tone_hit              w_hit;
    dpk_pkg::t_key_event             w_evt;

    // Advance the input register unless a final bin meets a full result register
    assign w_out_free    = !w_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_bin  <= s_axis_tdata[dpk_pkg::BIN_W-1:0];
            r_in_mag  <= s_axis_tdata[dpk_pkg::BIN_W +: dpk_pkg::MAG_W];
            r_in_last <= s_axis_tlast;
        end
    end

    // Load configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= dpk_pkg::THRESHOLD_RESET;
            r_passcode  <= dpk_pkg::PASSCODE_RESET;
        end else if (i_cfg_we) begin
            unique case (dpk_pkg::t_cfg_reg'(i_cfg_index))
                dpk_pkg::CFG_MAG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[dpk_pkg::MAG_W-1:0];
                end
                dpk_pkg::CFG_PASSCODE_KEYS: begin
                    r_passcode <= i_cfg_data[dpk_pkg::PASS_W-1:0];
                end
                default: begin
                    r_threshold <= r_threshold;
                end
            endcase
        end
    end

    dpk_tone_match u_tone_match (
        .i_bin (r_in_bin),
        .o_hit (w_hit)
    );

    dpk_peak_track u_peak_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_mag       (r_in_mag),
        .i_last      (r_in_last),
        .i_hit       (w_hit),
        .i_threshold (r_threshold),
        .o_evt       (w_evt)
    );

    dpk_entry_check u_entry_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (w_evt),
        .i_passcode     (r_passcode),
        .i_out_ready    (m_axis_tready),
        .o_valid        (w_out_valid),
        .o_key_valid    (w_key_valid),
        .o_key_code     (w_key_code),
        .o_keys_entered (w_entered),
        .o_verdict      (w_verdict)
    );

    // Pack the result request
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tuser  = w_key_valid;
    assign m_axis_tdata  = {7'b0, w_verdict, w_entered, w_key_code};

endmodule

`default_nettype wire

[bench/key_check_pkg.sv]
// ----------------------------------------------------------------------------
// key_check_pkg
// Key and passcode predictor with the queue of expected key reports.
// ----------------------------------------------------------------------------
// The tracker mirrors the detector state bin by bin: peak search on the
// row and column tone windows, key decision at the capture end, entry
// collection and passcode verdict. Each capture end queues one expected
// report, and every report taken from the block is compared against the
// oldest entry field by field.
// ----------------------------------------------------------------------------
package key_check_pkg;

    import dpk_pkg::*;

    localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};
    localparam int unsigned NO_PICK    = 4;

    typedef struct {
        logic           key_valid;
        logic [3:0]     key_code;
        logic [2:0]     keys_entered;
        t_verdict       verdict;
    } t_key_result;

    class key_entry_tracker;

        logic [22:0]    threshold;
        logic [15:0]    passcode;
        logic [22:0]    row_peak;
        logic [22:0]    col_peak;
        int unsigned    row_pick;
        int unsigned    col_pick;
        logic [3:0]     entry [4];
        int unsigned    key_count;
        t_key_result    pending_keys [$];

        int unsigned    errors;
        int unsigned    bins_seen;
        int unsigned    captures;
        int unsigned    keys_taken;
        int unsigned    correct_entries;
        int unsigned    wrong_entries;

        function new();
            threshold = THRESHOLD_RESET;
            passcode  = PASSCODE_RESET;
            key_count = 0;
            clear_peaks();
        endfunction

        function void clear_peaks();
            row_peak = '0;
            col_peak = '0;
            row_pick = NO_PICK;
            col_pick = NO_PICK;
        endfunction

        function void load_reg(t_cfg_reg idx, logic [22:0] value);
            if (idx == CFG_MAG_THRESHOLD) begin
                threshold = value;
            end else begin
                passcode = value[15:0];
            end
        endfunction

        // Exact integer window test: (f-10)*N < bin*fs < (f+10)*N
        function bit near_tone(logic [8:0] bin, int unsigned tone_hz);
            longint unsigned scaled;
            longint unsigned lo;
            longint unsigned hi;
            scaled = longint'(bin) * SAMPLE_RATE_HZ;
            lo     = longint'(tone_hz - HALF_WINDOW_HZ) * TRANSFORM_LENGTH;
            hi     = longint'(tone_hz + HALF_WINDOW_HZ) * TRANSFORM_LENGTH;
            return (scaled > lo) && (scaled < hi);
        endfunction

        // Advance the peak search; at the capture end queue the key report
        function void note_bin(logic [8:0] bin, logic [22:0] mag, logic last);
            t_key_result want;
            bit          accepted;
            bit          match;
            bins_seen++;
            for (int t = 0; t < 4; t++) begin
                if (near_tone(bin, ROW_HZ[t]) && mag > row_peak) begin
                    row_peak = mag;
                    row_pick = t;
                end
                if (near_tone(bin, COL_HZ[t]) && mag > col_peak) begin
                    col_peak = mag;
                    col_pick = t;
                end
            end
            if (!last) begin
                return;
            end
            captures++;
            accepted = (row_peak > threshold) && (col_peak > threshold) &&
                       (row_pick < NO_PICK) && (col_pick < NO_PICK);
            want.key_valid = accepted;
            want.key_code  = '0;
            if (accepted) begin
                want.key_code = 4'(row_pick * 4 + col_pick);
                if (key_count < CODE_LENGTH) begin
                    entry[key_count] = want.key_code;
                    key_count++;
                end
                keys_taken++;
            end
            clear_peaks();
            want.keys_entered = 3'(key_count);
            want.verdict      = VERDICT_INCOMPLETE;
            if (key_count >= CODE_LENGTH) begin
                match = 1'b1;
                for (int t = 0; t < 4; t++) begin
                    if (entry[t] != passcode[4*t +: 4]) begin
                        match = 1'b0;
                    end
                end
                want.verdict = match ? VERDICT_CORRECT : VERDICT_INCORRECT;
                key_count = 0;
            end
            pending_keys.push_back(want);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got,
                                    longint unsigned stamp);
            if (got !== want) begin
                errors++;
                $display("%0d ns: %s expected %0d, got %0d", stamp, name, want, got);
            end
        endfunction

        // Compare one key report against the oldest expectation
        function void check_key(logic [15:0] data, logic [0:0] user,
                                longint unsigned stamp);
            t_key_result want;
            if (pending_keys.size() == 0) begin
                errors++;
                $display("%0d ns: key report with nothing pending: tdata %h tuser %b",
                         stamp, data, user);
                return;
            end
            want = pending_keys.pop_front();
            compare_field("key_valid", 4'(want.key_valid), 4'(user[0]), stamp);
            compare_field("key_code", want.key_code, data[3:0], stamp);
            compare_field("keys_entered", 4'(want.keys_entered), 4'(data[6:4]), stamp);
            compare_field("verdict", 4'(want.verdict), 4'(data[8:7]), stamp);
            if (want.verdict == VERDICT_CORRECT) begin
                correct_entries++;
            end else if (want.verdict == VERDICT_INCORRECT) begin
                wrong_entries++;
            end
        endfunction

    endclass

endpackage

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Bench for the DTMF peak key detector with passcode check.
// ----------------------------------------------------------------------------
// Streams spectrum captures into the block: a directed set covering the
// magnitude extremes, zero and equal peaks, the threshold boundary, peak
// clearing between captures and full correct and incorrect entries, then
// random captures over several threshold and passcode settings. Both
// handshake sides idle at random, and the receiver holds off once for a
// long stretch so the block back-pressures. Reports are checked against
// the key_entry_tracker predictor.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dpk_pkg::*;
    import key_check_pkg::*;

    localparam logic [22:0] MAG_MAX      = 23'h7FFFFF;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned HOLD_OFF     = 400;
    localparam int unsigned ROW_BIN [4]  = '{36, 39, 44, 48};
    localparam int unsigned COL_BIN [4]  = '{62, 68, 76, 84};

    typedef struct {
        logic [8:0]  bin;
        logic [22:0] mag;
        logic        last;
    } t_bin_req;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we;
    t_cfg_reg       i_cfg_index;
    logic [22:0]    i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [31:0]    s_axis_tdata;
    logic           s_axis_tlast;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [15:0]    m_axis_tdata;
    logic [0:0]     m_axis_tuser;

    key_entry_tracker tracker = new();
    t_bin_req         capture_q [$];
    bit               no_gaps;
    int unsigned      hold_request;
    int unsigned      idle_cycles;
    int unsigned      settings_run;

    dtmf_peak_key_passcode i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Offer one bin request, hold it until accepted, then note it
    task automatic send_bin(t_bin_req req);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(5, 0);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.mag, req.bin};
        s_axis_tlast  <= req.last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        tracker.note_bin(req.bin, req.mag, req.last);
    endtask

    task automatic add_bin(int unsigned bin, logic [22:0] mag);
        t_bin_req req;
        req.bin  = 9'(bin);
        req.mag  = mag;
        req.last = 1'b0;
        capture_q.push_back(req);
    endtask

    // Mark the final bin and stream the whole capture
    task automatic send_capture();
        capture_q[capture_q.size()-1].last = 1'b1;
        foreach (capture_q[i]) begin
            send_bin(capture_q[i]);
        end
        capture_q.delete();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [22:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.load_reg(idx, value);
    endtask

    // Wait for every report, then let any trailing bin clear the pipeline
    task automatic wait_drained();
        while (tracker.pending_keys.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Magnitude that clears the threshold, the boundary value now and then
    function automatic logic [22:0] strong_mag();
        if (tracker.threshold >= MAG_MAX) begin
            return 23'($urandom_range(MAG_MAX, 0));
        end
        if ($urandom_range(7, 0) == 0) begin
            return tracker.threshold + 23'd1;
        end
        return 23'($urandom_range(MAG_MAX, tracker.threshold + 1));
    endfunction

    // Magnitude around the threshold or the range extremes
    function automatic logic [22:0] edge_mag();
        case ($urandom_range(4, 0))
            0: return '0;
            1: return tracker.threshold;
            2: return (tracker.threshold == MAG_MAX) ? MAG_MAX : tracker.threshold + 23'd1;
            3: return MAG_MAX;
            default: return 23'($urandom_range(MAG_MAX, 0));
        endcase
    endfunction

    // Tone bin or one of its neighbors, to probe the window edges
    function automatic int unsigned near_tone_bin();
        int unsigned tone;
        tone = $urandom_range(7, 0);
        tone = (tone < 4) ? ROW_BIN[tone] : COL_BIN[tone-4];
        return tone + $urandom_range(2, 0) - 1;
    endfunction

    task automatic random_capture();
        int unsigned kind;
        int unsigned key;
        logic [22:0] row_mag;
        logic [22:0] col_mag;
        logic [22:0] cap;
        t_bin_req    req;
        kind = $urandom_range(99, 0);
        if (kind < 65) begin
            // well-formed key, mostly the next passcode digit
            if ($urandom_range(99, 0) < 80) begin
                key = tracker.passcode[4*tracker.key_count +: 4];
            end else begin
                key = $urandom_range(15, 0);
            end
            row_mag = strong_mag();
            col_mag = strong_mag();
            add_bin(ROW_BIN[key/4], row_mag);
            add_bin(COL_BIN[key%4], col_mag);
            cap = (row_mag < col_mag) ? row_mag : col_mag;
            repeat ($urandom_range(3, 0)) begin
                req.bin  = $urandom_range(1, 0) ? 9'(near_tone_bin()) :
                                                  9'($urandom_range(511, 0));
                req.mag  = 23'($urandom_range(cap, 0));
                req.last = 1'b0;
                capture_q.insert($urandom_range(capture_q.size(), 0), req);
            end
            if ($urandom_range(4, 0) == 0) begin
                add_bin($urandom_range(511, 0), 23'($urandom_range(MAG_MAX, 0)));
            end
        end else if (kind < 88) begin
            // broken capture: scattered bins with boundary magnitudes
            repeat ($urandom_range(4, 1)) begin
                add_bin($urandom_range(1, 0) ? near_tone_bin() : $urandom_range(511, 0),
                        edge_mag());
            end
        end else begin
            add_bin($urandom_range(511, 0), 23'($urandom_range(MAG_MAX, 0)));
        end
        send_capture();
    endtask

    task automatic run_phase(logic [22:0] thr, logic [15:0] pass, int unsigned quota,
                             bit gapless, bit pressure);
        int unsigned start;
        wait_drained();
        write_reg(CFG_MAG_THRESHOLD, thr);
        write_reg(CFG_PASSCODE_KEYS, 23'(pass));
        settings_run++;
        no_gaps = gapless;
        if (pressure) begin
            hold_request = HOLD_OFF;
        end
        start = tracker.bins_seen;
        while (tracker.bins_seen - start < quota) begin
            random_capture();
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin : rx_side
        int unsigned stall;
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
                repeat (hold) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
            stall = no_gaps ? 0 : $urandom_range(5, 0);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
            tracker.check_key(m_axis_tdata, m_axis_tuser, $time);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("dtmf_peak_key_passcode: mismatch");
        $finish;
    end

    initial begin : main
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MAG_THRESHOLD;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        no_gaps       = 1'b0;
        hold_request  = 0;
        settings_run  = 1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed captures under the reset settings
        add_bin(36, MAG_MAX);
        add_bin(62, MAG_MAX);
        add_bin(0, '0);
        send_capture();
        // zero magnitudes never set a peak
        add_bin(39, '0);
        add_bin(68, '0);
        send_capture();
        // equal later peaks keep the earlier tone
        add_bin(44, 23'd50000);
        add_bin(36, 23'd50000);
        add_bin(76, 23'd30000);
        add_bin(84, 23'd30000);
        send_capture();
        // row peak equal to the threshold is rejected
        add_bin(48, 23'd20000);
        add_bin(62, 23'd20001);
        send_capture();
        // peaks cleared after the previous capture
        add_bin(84, 23'd30000);
        send_capture();
        add_bin(511, MAG_MAX);
        add_bin(36, 23'd20001);
        add_bin(68, 23'd20001);
        send_capture();
        // fourth key closes an incorrect entry
        add_bin(48, 23'd25000);
        add_bin(84, 23'd25000);
        send_capture();
        // correct entry for the reset passcode: 6, 8, 1, 0
        add_bin(39, 23'd100000);
        add_bin(76, 23'd100000);
        send_capture();
        add_bin(44, 23'd100000);
        add_bin(62, 23'd100000);
        send_capture();
        add_bin(36, 23'd100000);
        add_bin(68, 23'd100000);
        send_capture();
        add_bin(36, 23'd100000);
        add_bin(62, 23'd100000);
        send_capture();

        // Random captures over several register settings
        run_phase('0, 16'h0000, 300, 1'b0, 1'b0);
        run_phase(MAG_MAX, 16'hFFFF, 80, 1'b1, 1'b0);
        run_phase(23'($urandom_range(1000, 1)), 16'($urandom_range(65535, 0)), 300,
                  1'b0, 1'b0);
        run_phase(23'($urandom_range(MAG_MAX, 0)), 16'($urandom_range(65535, 0)), 300,
                  1'b0, 1'b1);
        run_phase(23'd20000, 16'h0186, 300, 1'b0, 1'b0);
        run_phase(23'($urandom_range(MAG_MAX - 1, 0)), 16'($urandom_range(65535, 0)), 300,
                  1'b1, 1'b0);
        run_phase(23'd1, 16'hFFFF, 150, 1'b0, 1'b0);
        wait_drained();

        $display("Streamed %0d bins in %0d captures, %0d keys accepted, %0d settings.",
                 tracker.bins_seen, tracker.captures, tracker.keys_taken, settings_run);
        $display("Entries closed: %0d correct, %0d incorrect.",
                 tracker.correct_entries, tracker.wrong_entries);
        if (tracker.errors == 0) begin
            $display("dtmf_peak_key_passcode: match");
        end else begin
            $display("dtmf_peak_key_passcode: mismatch");
        end
        $finish;
    end

endmodule
